// File: hw/rtl/kne_pkg.sv
// shared types, constants and the key table for the keypad number entry block
// no dependencies; the other files, kne_chan_if apart, refer to it by scoped names

package kne_pkg;

   localparam int MAX_DIGITS  = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam int COL_W   = 4;
   localparam int KEY_W   = 4;
   localparam int CODE_W  = 8;
   localparam int DIGIT_W = 4;
   localparam int VALUE_W = 10;
   localparam int COUNT_W = 2;
   localparam int END_W   = 2;

   localparam logic [CODE_W-1:0] ASCII_ZERO = 8'h30;
   localparam logic [CODE_W-1:0] ASCII_NINE = 8'h39;
   localparam logic [CODE_W-1:0] ASCII_B    = 8'h42;
   localparam logic [CODE_W-1:0] ASCII_C    = 8'h43;
   localparam logic [CODE_W-1:0] ASCII_D    = 8'h44;
   localparam logic [CODE_W-1:0] ASCII_E    = 8'h45;

   localparam logic [COL_W-1:0] COLS_RELEASED = 4'hF;
   localparam logic [COL_W-1:0] ROWS_ALL_LOW  = 4'h0;
   localparam logic [COL_W-1:0] ROW0_LOW      = 4'hE;

   localparam logic [END_W-1:0] END_KEY_E = 2'd0;
   localparam logic [END_W-1:0] END_KEY_B = 2'd1;
   localparam logic [END_W-1:0] END_KEY_D = 2'd2;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_SCAN    = 2'd1,
      PH_RELEASE = 2'd2
   } scan_phase_type;

   typedef struct packed {
      logic [COL_W-1:0] column_levels;
   } req_type;

   typedef struct packed {
      logic [COL_W-1:0]   row_drive;
      logic               key_event;
      logic [CODE_W-1:0]  key_code;
      logic               echo_valid;
      logic [DIGIT_W-1:0] echo_digit;
      logic               erase_echo;
      logic               rejected;
      logic               entry_done;
      logic [VALUE_W-1:0] entry_value;
      logic [END_W-1:0]   end_key;
      logic [COUNT_W-1:0] digits_held;
   } rsp_type;

   typedef struct packed {
      logic edit_mode;
   } csr_type;

   // one scanner tick as handed to the entry logic
   typedef struct packed {
      logic [COL_W-1:0] row_drive;
      logic             key_event;
      logic [KEY_W-1:0] key_index;
   } scan_rec_type;

   function automatic logic [CODE_W-1:0] key_ascii(input logic [KEY_W-1:0] idx);
      logic [CODE_W-1:0] code;
      unique case (idx)
         4'd0:    code = 8'h31;
         4'd1:    code = 8'h32;
         4'd2:    code = 8'h33;
         4'd3:    code = 8'h41;
         4'd4:    code = 8'h34;
         4'd5:    code = 8'h35;
         4'd6:    code = 8'h36;
         4'd7:    code = 8'h42;
         4'd8:    code = 8'h37;
         4'd9:    code = 8'h38;
         4'd10:   code = 8'h39;
         4'd11:   code = 8'h43;
         4'd12:   code = 8'h45;
         4'd13:   code = 8'h30;
         4'd14:   code = 8'h2A;
         default: code = 8'h44;
      endcase
      return code;
   endfunction

endpackage

// File: hw/rtl/kne_chan_if.sv
// valid/ready channel carrying one payload struct per transfer
// payload types come from kne_pkg

interface kne_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/kne_front.sv
// row scanner: samples columns, walks the rows, finds the key and waits for release
// depends on kne_pkg and kne_chan_if

module kne_front (
   input  logic                  clock,
   input  logic                  reset,
   kne_chan_if.sink              req_chan,
   input  logic                  queue_full,
   output logic                  push,
   output kne_pkg::scan_rec_type push_data
);

   kne_pkg::scan_phase_type phase_ff, phase_in;
   logic [1:0]              row_ff, row_in;
   logic [kne_pkg::KEY_W-1:0] found_ff, found_in;
   logic [kne_pkg::COL_W-1:0] cols;
   logic                    pressed;
   logic [1:0]              low_col;
   logic [1:0]              next_row;

   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;
   assign cols           = req_chan.payload.column_levels;
   assign pressed        = cols != kne_pkg::COLS_RELEASED;
   assign next_row       = row_ff + 2'd1;

   always_comb begin
      priority if (!cols[0]) low_col = 2'd0;
      else if (!cols[1])     low_col = 2'd1;
      else if (!cols[2])     low_col = 2'd2;
      else                   low_col = 2'd3;
   end

   // next state
   always_comb begin
      unique case (phase_ff)
         kne_pkg::PH_SCAN: begin
            if (pressed)            phase_in = kne_pkg::PH_RELEASE;
            else if (row_ff == 2'd3) phase_in = kne_pkg::PH_IDLE;
            else                    phase_in = kne_pkg::PH_SCAN;
         end
         kne_pkg::PH_RELEASE: begin
            phase_in = pressed ? kne_pkg::PH_RELEASE : kne_pkg::PH_IDLE;
         end
         default: begin
            phase_in = pressed ? kne_pkg::PH_SCAN : kne_pkg::PH_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      row_in              = row_ff;
      found_in            = found_ff;
      push_data.row_drive = kne_pkg::ROWS_ALL_LOW;
      push_data.key_event = 1'b0;
      push_data.key_index = found_ff;
      unique case (phase_ff)
         kne_pkg::PH_SCAN: begin
            if (pressed) begin
               found_in = {row_ff, low_col};
            end else if (row_ff == 2'd3) begin
               row_in = 2'd0;
            end else begin
               row_in              = next_row;
               push_data.row_drive = ~(4'b0001 << next_row);
            end
         end
         kne_pkg::PH_RELEASE: begin
            push_data.key_event = !pressed;
         end
         default: begin
            if (pressed) begin
               row_in              = 2'd0;
               push_data.row_drive = kne_pkg::ROW0_LOW;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= kne_pkg::PH_IDLE;
         row_ff   <= 2'd0;
         found_ff <= '0;
      end else if (push) begin
         phase_ff <= phase_in;
         row_ff   <= row_in;
         found_ff <= found_in;
      end
   end

endmodule

// File: hw/rtl/kne_queue.sv
// short fifo of scanner records between the scanner and the entry logic
// depends on kne_pkg

module kne_queue #(
   parameter int DEPTH = kne_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  kne_pkg::scan_rec_type push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  pop_valid,
   output kne_pkg::scan_rec_type pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   kne_pkg::scan_rec_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: hw/rtl/kne_back.sv
// number entry: decodes released keys, keeps the number and digit count,
// holds the edit mode register and the result output register; depends on kne_pkg

module kne_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   input  kne_pkg::scan_rec_type pop_data,
   output logic                  pop,
   kne_chan_if.source            rsp_chan,
   kne_chan_if.sink              csr_chan
);

   logic [kne_pkg::VALUE_W-1:0] number_ff, number_in;
   logic [kne_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        edit_ff;
   logic                        rsp_valid_ff;
   kne_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic [kne_pkg::CODE_W-1:0]  key;
   logic [kne_pkg::CODE_W-1:0]  key_offset;
   logic [kne_pkg::DIGIT_W-1:0] digit;
   logic                        is_digit;
   logic [17:0]                 quot_prod;
   logic [kne_pkg::VALUE_W-1:0] quot;
   logic [kne_pkg::VALUE_W-1:0] appended;

   assign pop            = pop_valid && (!rsp_valid_ff || rsp_chan.ready);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;
   assign csr_chan.ready = 1'b1;

   assign key        = kne_pkg::key_ascii(pop_data.key_index);
   assign key_offset = key - kne_pkg::ASCII_ZERO;
   assign digit      = key_offset[kne_pkg::DIGIT_W-1:0];
   assign is_digit   = (key >= kne_pkg::ASCII_ZERO) && (key <= kne_pkg::ASCII_NINE);
   // divide by ten as multiply by 205/2048, exact below 1029
   assign quot_prod  = {8'd0, number_ff} * 18'd205;
   assign quot       = {3'd0, quot_prod[17:11]};
   assign appended   = (number_ff << 3) + (number_ff << 1)
                       + {{(kne_pkg::VALUE_W-kne_pkg::DIGIT_W){1'b0}}, digit};

   always_comb begin
      number_in   = number_ff;
      count_in    = count_ff;
      rsp_data_in = '0;
      rsp_data_in.row_drive = pop_data.row_drive;
      if (pop_data.key_event) begin
         rsp_data_in.key_event = 1'b1;
         rsp_data_in.key_code  = key;
         priority if (is_digit) begin
            if (count_ff < kne_pkg::COUNT_W'(kne_pkg::MAX_DIGITS)) begin
               number_in              = appended;
               count_in               = count_ff + 1'b1;
               rsp_data_in.echo_valid = 1'b1;
               rsp_data_in.echo_digit = digit;
            end else begin
               number_in            = '0;
               count_in             = '0;
               rsp_data_in.rejected = 1'b1;
            end
         end else if (key == kne_pkg::ASCII_C) begin
            if (count_ff != '0) begin
               number_in              = quot;
               count_in               = count_ff - 1'b1;
               rsp_data_in.erase_echo = 1'b1;
            end
         end else if (key == kne_pkg::ASCII_E) begin
            rsp_data_in.entry_done = 1'b1;
            rsp_data_in.end_key    = kne_pkg::END_KEY_E;
         end else if (edit_ff && key == kne_pkg::ASCII_B) begin
            rsp_data_in.entry_done = 1'b1;
            rsp_data_in.end_key    = kne_pkg::END_KEY_B;
         end else if (edit_ff && key == kne_pkg::ASCII_D) begin
            rsp_data_in.entry_done = 1'b1;
            rsp_data_in.end_key    = kne_pkg::END_KEY_D;
         end else begin
            // other keys are only reported
            rsp_data_in.entry_done = 1'b0;
         end
      end
      rsp_data_in.entry_value = number_in;
      if (rsp_data_in.entry_done) begin
         number_in = '0;
         count_in  = '0;
      end
      rsp_data_in.digits_held = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         number_ff    <= '0;
         count_ff     <= '0;
         edit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            edit_ff <= csr_chan.payload.edit_mode;
         end
         if (pop) begin
            number_ff    <= number_in;
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_number_fits_count: assert property (@(posedge clock) disable iff (reset)
      ((count_ff == 2'd0) && (number_ff == 10'd0)) ||
      ((count_ff == 2'd1) && (number_ff < 10'd10)) ||
      ((count_ff == 2'd2) && (number_ff < 10'd100)) ||
      ((count_ff == 2'd3) && (number_ff < 10'd1000)))
      else $error("number out of range for digit count");

   a_pop_fills_output: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("popped record did not reach the output register");

   a_done_clears_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.entry_done) |-> (rsp_data_ff.digits_held == '0))
      else $error("finished entry left digits held");

   a_single_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_data_ff.echo_valid, rsp_data_ff.erase_echo,
                                 rsp_data_ff.rejected, rsp_data_ff.entry_done}))
      else $error("more than one entry action in one result");

endmodule

// File: hw/rtl/keypad_number_entry_top.sv
// top level of the keypad number entry block: scanner, record queue, entry logic
// depends on kne_pkg, kne_chan_if, kne_front, kne_queue and kne_back
//
// req_chan carries one sample of the active-low keypad columns per transfer.
// rsp_chan returns exactly one result per sample: the row levels to drive
// before the next sample plus any key event, echo, erase, reject or finished
// entry with the current number and digit count.
// csr_chan writes the edit mode bit; it is always ready and is meant to be
// written while no samples are in flight.
// a transferred sample is written into the queue and its result is then loaded
// into the result register that drives rsp_chan. throughput: one sample per
// cycle while rsp_chan does not stall; scanner and entry logic take new records.
// when rsp_chan stalls, the result register holds and up to QUEUE_DEPTH
// scanner records collect in the queue; then req_chan ready drops.
// reset (synchronous) puts the scanner in idle with all rows low, clears the
// number, digit count and edit mode, and empties the queue.

module keypad_number_entry_top #(
   parameter int QUEUE_DEPTH = kne_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   kne_chan_if.sink   req_chan,
   kne_chan_if.source rsp_chan,
   kne_chan_if.sink   csr_chan
);

   logic                  push;
   logic                  queue_full;
   kne_pkg::scan_rec_type push_data;
   logic                  pop;
   logic                  pop_valid;
   kne_pkg::scan_rec_type pop_data;

   kne_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   kne_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_data  (pop_data)
   );

   kne_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_chan  (rsp_chan),
      .csr_chan  (csr_chan)
   );

endmodule

// File: tb/tb_keypad_number_entry_top.sv
// self-checking testbench for keypad_number_entry_top
// keypad press sequences in, one result per sample out
// depends on kne_pkg, kne_chan_if and the keypad_number_entry_top rtl

module tb_keypad_number_entry_top;

   localparam int          QUIET_LIMIT = 2000;
   localparam int unsigned IDLE_PCT    = 11;
   localparam byte         KEY_A       = "A";
   localparam byte         KEY_STAR    = "*";

   logic clock = 1'b0;
   logic reset;
   bit   steady = 1'b0;
   int   error_count = 0;
   int   quiet_cycles = 0;
   int unsigned queued_count = 0;

   string key_map = "123A456B789CE0*D";

   logic [kne_pkg::COL_W-1:0] sample_queue[$];
   kne_pkg::rsp_type          pending_results[$];

   // scanner and entry state as predicted
   kne_pkg::scan_phase_type     scan_state  = kne_pkg::PH_IDLE;
   logic [1:0]                  scan_line   = '0;
   logic [kne_pkg::KEY_W-1:0]   held_key    = '0;
   logic [kne_pkg::VALUE_W-1:0] number_acc  = '0;
   logic [kne_pkg::COUNT_W-1:0] digit_tally = '0;
   logic                        edit_mode_bit = 1'b0;

   kne_chan_if #(.payload_type(kne_pkg::req_type)) req_if ();
   kne_chan_if #(.payload_type(kne_pkg::rsp_type)) rsp_if ();
   kne_chan_if #(.payload_type(kne_pkg::csr_type)) csr_if ();

   keypad_number_entry_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #10 clock = ~clock;

   function automatic kne_pkg::rsp_type scan_tick(logic [kne_pkg::COL_W-1:0] cols);
      kne_pkg::rsp_type       res;
      logic [kne_pkg::CODE_W-1:0] code;
      logic [1:0]             col;
      res = '0;
      col = '0;
      case (scan_state)
         kne_pkg::PH_SCAN: begin
            if (cols != kne_pkg::COLS_RELEASED) begin
               for (int i = 3; i >= 0; i--) begin
                  if (!cols[i]) col = 2'(i);
               end
               held_key   = {scan_line, col};
               scan_state = kne_pkg::PH_RELEASE;
            end else if (scan_line == 2'd3) begin
               scan_state = kne_pkg::PH_IDLE;
               scan_line  = '0;
            end else begin
               scan_line     = scan_line + 2'd1;
               res.row_drive = ~(4'b0001 << scan_line);
            end
         end
         kne_pkg::PH_RELEASE: begin
            if (cols == kne_pkg::COLS_RELEASED) begin
               code          = key_map[held_key];
               scan_state    = kne_pkg::PH_IDLE;
               res.key_event = 1'b1;
               res.key_code  = code;
               if (code >= kne_pkg::ASCII_ZERO && code <= kne_pkg::ASCII_NINE) begin
                  if (int'(digit_tally) < kne_pkg::MAX_DIGITS) begin
                     number_acc     = 10'(number_acc * 10 + 32'(code - kne_pkg::ASCII_ZERO));
                     digit_tally    = digit_tally + 2'd1;
                     res.echo_valid = 1'b1;
                     res.echo_digit = 4'(code - kne_pkg::ASCII_ZERO);
                  end else begin
                     number_acc   = '0;
                     digit_tally  = '0;
                     res.rejected = 1'b1;
                  end
               end else if (code == kne_pkg::ASCII_C) begin
                  if (digit_tally != 2'd0) begin
                     number_acc     = 10'(number_acc / 10);
                     digit_tally    = digit_tally - 2'd1;
                     res.erase_echo = 1'b1;
                  end
               end else if (code == kne_pkg::ASCII_E) begin
                  res.entry_done = 1'b1;
                  res.end_key    = kne_pkg::END_KEY_E;
               end else if (edit_mode_bit && code == kne_pkg::ASCII_B) begin
                  res.entry_done = 1'b1;
                  res.end_key    = kne_pkg::END_KEY_B;
               end else if (edit_mode_bit && code == kne_pkg::ASCII_D) begin
                  res.entry_done = 1'b1;
                  res.end_key    = kne_pkg::END_KEY_D;
               end
            end
         end
         default: begin
            scan_state = kne_pkg::PH_IDLE;
            if (cols != kne_pkg::COLS_RELEASED) begin
               scan_state    = kne_pkg::PH_SCAN;
               scan_line     = '0;
               res.row_drive = kne_pkg::ROW0_LOW;
            end
         end
      endcase
      res.entry_value = number_acc;
      if (res.entry_done) begin
         number_acc  = '0;
         digit_tally = '0;
      end
      res.digits_held = digit_tally;
      return res;
   endfunction

   function automatic logic [kne_pkg::KEY_W-1:0] key_index_of(byte ch);
      logic [kne_pkg::KEY_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < 16; i++) begin
         if (key_map[i] == ch) idx = 4'(i);
      end
      return idx;
   endfunction

   task automatic queue_sample(logic [kne_pkg::COL_W-1:0] cols);
      sample_queue.push_back(cols);
      queued_count++;
   endtask

   // press from idle, row scan up to the key's row, hold, then release
   task automatic press_key(byte ch, int unsigned hold);
      logic [kne_pkg::KEY_W-1:0] idx;
      logic [kne_pkg::COL_W-1:0] lows;
      idx  = key_index_of(ch);
      lows = ~(4'b0001 << idx[1:0]);
      queue_sample(lows & 4'($urandom_range(15)));
      repeat (int'(idx[3:2])) queue_sample(kne_pkg::COLS_RELEASED);
      queue_sample(($urandom_range(4) == 0) ? (lows & 4'($urandom_range(15))) : lows);
      repeat (hold) queue_sample(4'($urandom_range(14)));
      queue_sample(kne_pkg::COLS_RELEASED);
   endtask

   task automatic fill_entries(int unsigned target);
      int unsigned start;
      start = queued_count;
      while (queued_count - start < target) begin
         if ($urandom_range(99) < 8) begin
            repeat ($urandom_range(1, 6)) queue_sample(4'($urandom_range(15)));
            repeat (5) queue_sample(kne_pkg::COLS_RELEASED);
         end else begin
            repeat ($urandom_range(4)) begin
               press_key(8'(kne_pkg::ASCII_ZERO + $urandom_range(9)), $urandom_range(3));
               if ($urandom_range(99) < 15) press_key(kne_pkg::ASCII_C, $urandom_range(2));
               if ($urandom_range(99) < 5)
                  press_key($urandom_range(1) ? KEY_A : KEY_STAR, $urandom_range(2));
               repeat ($urandom_range(2)) queue_sample(kne_pkg::COLS_RELEASED);
            end
            case ($urandom_range(4))
               0, 1: press_key(kne_pkg::ASCII_E, $urandom_range(3));
               2:    press_key(kne_pkg::ASCII_B, $urandom_range(3));
               3:    press_key(kne_pkg::ASCII_D, $urandom_range(3));
               default: begin
                  press_key(kne_pkg::ASCII_C, $urandom_range(3));
                  press_key(kne_pkg::ASCII_E, $urandom_range(3));
               end
            endcase
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (sample_queue.size() != 0 || req_if.valid || pending_results.size() != 0);
   endtask

   task automatic write_edit_mode(logic mode);
      @(posedge clock);
      csr_if.valid             <= 1'b1;
      csr_if.payload.edit_mode <= mode;
      do @(posedge clock);
      while (!csr_if.ready);
      csr_if.valid  <= 1'b0;
      edit_mode_bit = mode;
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s expected %0d got %0d", name, want, got);
         error_count++;
      end
   endtask

   // sample driver, prediction on each accepted transfer
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready)
            pending_results.push_back(scan_tick(req_if.payload.column_levels));
         if (!req_if.valid || req_if.ready) begin
            if (sample_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               req_if.valid                  <= 1'b1;
               req_if.payload.column_levels <= sample_queue.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      kne_pkg::rsp_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= steady || $urandom_range(99) >= IDLE_PCT;
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_results.size() == 0) begin
               $error("result transfer with no sample outstanding");
               error_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("row_drive", want.row_drive, rsp_if.payload.row_drive);
               check_field("key_event", want.key_event, rsp_if.payload.key_event);
               check_field("key_code", want.key_code, rsp_if.payload.key_code);
               check_field("echo_valid", want.echo_valid, rsp_if.payload.echo_valid);
               check_field("echo_digit", want.echo_digit, rsp_if.payload.echo_digit);
               check_field("erase_echo", want.erase_echo, rsp_if.payload.erase_echo);
               check_field("rejected", want.rejected, rsp_if.payload.rejected);
               check_field("entry_done", want.entry_done, rsp_if.payload.entry_done);
               check_field("entry_value", want.entry_value, rsp_if.payload.entry_value);
               check_field("end_key", want.end_key, rsp_if.payload.end_key);
               check_field("digits_held", want.digits_held, rsp_if.payload.digits_held);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.payload = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // idle sample, then a press that no row scan finds
      queue_sample(kne_pkg::COLS_RELEASED);
      queue_sample(4'h0);
      repeat (4) queue_sample(kne_pkg::COLS_RELEASED);
      // all columns low on row 0, lowest column wins
      queue_sample(4'h0);
      queue_sample(4'h0);
      queue_sample(kne_pkg::COLS_RELEASED);
      press_key(kne_pkg::ASCII_C, 1);
      press_key(kne_pkg::ASCII_D, 0);
      press_key(kne_pkg::ASCII_E, 2);
      wait_drained();

      write_edit_mode(1'b1);
      steady = 1'b1;
      fill_entries(250);
      wait_drained();
      steady = 1'b0;

      write_edit_mode(1'b0);
      fill_entries(250);
      wait_drained();

      write_edit_mode(1'b1);
      fill_entries(250);
      wait_drained();

      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/kne_pkg.sv
hw/rtl/kne_chan_if.sv
hw/rtl/kne_front.sv
hw/rtl/kne_queue.sv
hw/rtl/kne_back.sv
hw/rtl/keypad_number_entry_top.sv
tb/tb_keypad_number_entry_top.sv
